[rtl/mcid_pkg.sv]
// Shared constants and types for the multi-channel integrating debouncer.
`default_nettype none
package mcid_pkg;

    localparam int CHANNELS     = 4;
    localparam int FIELD_W      = 4;
    localparam int COUNT_W      = 8;
    localparam int DATA_W       = 2 * FIELD_W;
    localparam int TDATA_W      = ((DATA_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] THRESH_RESET = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

    typedef struct packed {
        logic level;
        logic fall;
    } lane_out_t;

endpackage
`default_nettype wire

[rtl/mcid_lane.sv]
// One debounce channel: integrating counter, accepted level and sticky fall flag.
`default_nettype none
module mcid_lane
    import mcid_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               sample,
    input  wire logic               clr,
    input  wire logic [COUNT_W-1:0] threshold,
    output lane_out_t               result
);

    logic               level_reg;
    logic               level_next;
    logic               fall_reg;
    logic               fall_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_step;
    logic               fall_base;

    always_comb
    begin
        fall_base = fall_reg & ~clr;
        if (sample != level_reg)
        begin
            count_step = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
        end
        else
        begin
            count_step = (count_reg != '0) ? count_reg - COUNT_W'(1) : count_reg;
        end
        if (count_step >= threshold)
        begin
            count_next = '0;
            level_next = sample;
            fall_next  = fall_base | (level_reg & ~sample);
        end
        else
        begin
            count_next = count_step;
            level_next = level_reg;
            fall_next  = fall_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            fall_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (en)
        begin
            level_reg <= level_next;
            fall_reg  <= fall_next;
            count_reg <= count_next;
        end
    end

    assign result.level = level_next;
    assign result.fall  = fall_next;

endmodule
`default_nettype wire

[rtl/mcid_merge.sv]
// Merge stage: packs the lane results into the registered output item.
`default_nettype none
module mcid_merge
    import mcid_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire lane_out_t [FIELD_W-1:0] lanes,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output logic [TDATA_W-1:0]       m_tdata
);

    logic               valid_reg;
    logic [FIELD_W-1:0] levels_reg;
    logic [FIELD_W-1:0] falls_reg;
    logic [FIELD_W-1:0] levels_next;
    logic [FIELD_W-1:0] falls_next;

    always_comb
    begin
        for (int i = 0; i < FIELD_W; i++)
        begin
            levels_next[i] = lanes[i].level;
            falls_next[i]  = lanes[i].fall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            levels_reg <= levels_next;
            falls_reg  <= falls_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = TDATA_W'({falls_reg, levels_reg});

endmodule
`default_nettype wire

[rtl/multi_channel_integrating_debouncer_unit.sv]
// Top level of the multi-channel integrating switch debouncer.
//
// Usage: each input item on s_* is one sample tick with a raw bit and a
// fall-flag clear bit per switch channel. Every item yields exactly one
// output item on m_* with the debounced levels and sticky fall flags as
// they stand after that tick.
// m_tvalid rises in the cycle after input acceptance. Throughput: one item per
// cycle while s_tready is high; all channel lanes update in parallel in the
// cycle the item is accepted, and a single output register holds the result.
// s_tready is high while the output register is empty or is being taken, so
// a stalled receiver stops input after one pending item and nothing is lost.
// The threshold register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high. Reset clears all levels, counters and flags,
// empties the output register and sets the threshold to 8.
`default_nettype none
module multi_channel_integrating_debouncer_unit
    import mcid_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,    // raw_samples[3:0], clear_falls[7:4]
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,    // stable_levels[3:0], fall_flags[7:4]
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COUNT_W-1:0] cfg_data
);

    logic [COUNT_W-1:0]      threshold_reg;
    logic                    accept;
    logic [FIELD_W-1:0]      raw;
    logic [FIELD_W-1:0]      clr;
    lane_out_t [FIELD_W-1:0] lanes;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_tvalid | m_tready;
    assign accept    = s_tvalid & s_tready;
    assign raw       = s_tdata[FIELD_W-1:0];
    assign clr       = s_tdata[DATA_W-1:FIELD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else if (cfg_valid)
        begin
            threshold_reg <= cfg_data;
        end
    end

    for (genvar ch = 0; ch < FIELD_W; ch++)
    begin : g_lane
        if (ch < CHANNELS)
        begin : g_used
            mcid_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (accept),
                .sample    (raw[ch]),
                .clr       (clr[ch]),
                .threshold (threshold_reg),
                .result    (lanes[ch])
            );
        end
        else
        begin : g_unused
            assign lanes[ch] = '0;
        end
    end

    mcid_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .lanes    (lanes),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
